### hw/rtl/xtea_pkg.sv
// Package for the XTEA counter-mode keystream block.
// Types and constants shared by the front, the queue and the cipher pipeline.
`default_nettype none
package xtea_pkg;
   localparam logic [31:0] ROUND_DELTA = 32'h9E3779B9;
   localparam int          SECOND_KEY_SHIFT = 11;

   localparam logic [2:0] REG_KEY0  = 3'd0;
   localparam logic [2:0] REG_KEY1  = 3'd1;
   localparam logic [2:0] REG_KEY2  = 3'd2;
   localparam logic [2:0] REG_KEY3  = 3'd3;
   localparam logic [2:0] REG_START = 3'd4;

   // one item after the front: counter already chosen, byte mask built
   typedef struct packed {
      logic [63:0] counter;
      logic [63:0] data_word;
      logic [63:0] mask;
      logic [3:0]  byte_count;
   } work_type;

   typedef struct packed {
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] sum;
   } round_type;

   function automatic logic [31:0] mix(input logic [31:0] v);
      mix = ((v << 4) ^ (v >> 5)) + v;
   endfunction
endpackage
`default_nettype wire

### hw/rtl/xtea_front.sv
// Front stage: accepts items, tracks the block counter, builds byte masks.
// Depends on xtea_pkg.
`default_nettype none
module xtea_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire logic [63:0]       data_word,
   input  wire logic [3:0]        byte_count,
   input  wire logic              start_of_message,
   input  wire logic [63:0]       start_counter,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output xtea_pkg::work_type     out_item
);
   logic [63:0]        counter_ff, counter_in;
   logic               valid_ff, valid_in;
   xtea_pkg::work_type item_ff, item_in;
   logic [63:0]        cur_ctr, mask;
   logic               take;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign cur_ctr   = start_of_message ? start_counter : counter_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      if (byte_count >= 4'd8) mask = '1;
      else if (byte_count == 4'd0) mask = '0;
      else mask = (64'd1 << {byte_count[2:0], 3'b000}) - 64'd1;
      item_in = item_ff;
      valid_in = valid_ff;
      counter_in = counter_ff;
      if (take) begin
         item_in.counter    = cur_ctr;
         item_in.data_word  = data_word;
         item_in.mask       = mask;
         item_in.byte_count = byte_count;
         counter_in = cur_ctr + 64'd1;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (reset) begin
         valid_ff   <= 1'b0;
         counter_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         counter_ff <= counter_in;
      end
   end

   property p_ctr_step;
      @(posedge clock) disable iff (reset) take |=> counter_ff == item_ff.counter + 64'd1;
   endproperty
   a_ctr_step: assert property (p_ctr_step) else $error("counter did not advance");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !out_ready |=> valid_ff && $stable(item_ff))
      else $error("front item lost under stall");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      take |=> valid_ff) else $error("taken item not held");
endmodule
`default_nettype wire

### hw/rtl/xtea_queue.sv
// Short FIFO between front and cipher pipeline (registered, depth 2).
// Depends on xtea_pkg.
`default_nettype none
module xtea_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire xtea_pkg::work_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output xtea_pkg::work_type     out_item
);
   xtea_pkg::work_type slot_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_item  = slot_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= in_item;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop)  rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue overflow");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> wp_ff == rp_ff)
      else $error("queue pointers inconsistent");
   a_push: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("push lost");
endmodule
`default_nettype wire

### hw/rtl/xtea_cipher.sv
// Back part: fully pipelined cipher, with output register.
// Depends on xtea_pkg.
`default_nettype none
module xtea_cipher #(
   parameter int CIPHER_CYCLES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [127:0]      key,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire xtea_pkg::work_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output logic [63:0]            result_word,
   output logic [3:0]             result_count
);
   // two half-rounds per round, each in its own stage
   localparam int NSTAGE = 2 * CIPHER_CYCLES;

   xtea_pkg::round_type st_ff [NSTAGE+1];
   xtea_pkg::work_type  it_ff [NSTAGE+1];
   logic [NSTAGE:0]     vld_ff;
   logic                adv;
   logic [63:0]         ks;

   // whole pipe stalls together when the last stage is full and not taken
   assign adv       = !vld_ff[NSTAGE] || out_ready;
   assign in_ready  = adv;
   assign out_valid = vld_ff[NSTAGE];
   assign ks        = {st_ff[NSTAGE].v1, st_ff[NSTAGE].v0};
   assign result_word  = it_ff[NSTAGE].data_word ^ (ks & it_ff[NSTAGE].mask);
   assign result_count = it_ff[NSTAGE].byte_count;

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff[0].v0  <= in_item.counter[31:0];
         st_ff[0].v1  <= in_item.counter[63:32];
         st_ff[0].sum <= xtea_pkg::ROUND_DELTA;
         it_ff[0]     <= in_item;
      end
   end

   for (genvar s = 0; s < NSTAGE; s++) begin : g_stage
      logic [31:0] kw;
      xtea_pkg::round_type nx;
      always_comb begin
         nx = st_ff[s];
         if (s % 2 == 0) begin
            kw = key[32*st_ff[s].sum[1:0] +: 32];
            nx.v0 = st_ff[s].v0 + (xtea_pkg::mix(st_ff[s].v1) ^ (st_ff[s].sum + kw));
         end else begin
            kw = key[32*st_ff[s].sum[xtea_pkg::SECOND_KEY_SHIFT+:2] +: 32];
            nx.v1 = st_ff[s].v1 + (xtea_pkg::mix(st_ff[s].v0) ^ (st_ff[s].sum + kw));
            nx.sum = st_ff[s].sum + xtea_pkg::ROUND_DELTA;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            st_ff[s+1] <= nx;
            it_ff[s+1] <= it_ff[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (adv) vld_ff <= {vld_ff[NSTAGE-1:0], in_valid};
   end

   a_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid && !out_ready |=> out_valid && $stable(result_word))
      else $error("result changed under stall");
   a_shift: assert property (@(posedge clock) disable iff (reset)
      adv |=> vld_ff[1] == $past(vld_ff[0])) else $error("pipe valid slip");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff)) else $error("pipe moved while stalled");
endmodule
`default_nettype wire

### hw/rtl/xtea_ctr_keystream_xor.sv
// XTEA-style counter-mode keystream XOR, top level.
// Holds config registers; joins xtea_front, xtea_queue and xtea_cipher.
//
// Input items (req_*) carry eight little-endian data bytes, a byte count and
// a start-of-message flag; each yields one result item (rsp_*) in order.
// Configuration (csr_*): index 0..3 key words, index 4 start counter; write
// only while the block is idle.
// Throughput: one item per cycle while rsp_ready stays high. Latency is set by
// the cipher pipeline, one stage per half-round plus its input register, and
// by the front register and the queue.
// Reset: key words 0, start counter 1, block counter 0, pipeline empty.
// When the receiver stalls, the whole cipher pipeline holds, the queue fills,
// and then req_ready drops; no item is lost.
`default_nettype none
module xtea_ctr_keystream_xor #(
   parameter int CIPHER_CYCLES = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_start_of_message,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_result_word,
   output logic [3:0]       rsp_result_count,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);
   logic [127:0] key_ff;
   logic [63:0]  start_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   xtea_pkg::work_type f_item, q_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= '0;
         start_ff <= 64'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            xtea_pkg::REG_KEY0:  key_ff[31:0]   <= csr_data[31:0];
            xtea_pkg::REG_KEY1:  key_ff[63:32]  <= csr_data[31:0];
            xtea_pkg::REG_KEY2:  key_ff[95:64]  <= csr_data[31:0];
            xtea_pkg::REG_KEY3:  key_ff[127:96] <= csr_data[31:0];
            xtea_pkg::REG_START: start_ff       <= csr_data;
            default: ;
         endcase
      end
   end

   xtea_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready),
      .data_word(req_data_word), .byte_count(req_byte_count),
      .start_of_message(req_start_of_message), .start_counter(start_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
   );

   xtea_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   xtea_cipher #(.CIPHER_CYCLES(CIPHER_CYCLES)) u_cipher (
      .clock, .reset, .key(key_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_valid), .out_ready(rsp_ready),
      .result_word(rsp_result_word), .result_count(rsp_result_count)
   );
endmodule
`default_nettype wire

### bench/testbench.sv
// Self-checking bench for xtea_ctr_keystream_xor: counter-mode keystream XOR.
// Depends on xtea_pkg for register indexes and the round constant; predicts results with its own cipher.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   localparam int ROUNDS = 32;
   localparam int LATENCY = 2 * ROUNDS + 3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = 4'd8;
   logic        req_start_of_message = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [63:0] rsp_result_word;
   logic [3:0]  rsp_result_count;
   logic        csr_write = 0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_data = '0;

   xtea_ctr_keystream_xor #(.CIPHER_CYCLES(ROUNDS)) dut (.*);

   always #1 clock = ~clock;

   // predictor state
   logic [31:0] key_copy [4];
   logic [63:0] nonce_copy;
   logic [63:0] ctr_copy;
   logic [63:0] want_word [$];
   logic [3:0]  want_count [$];
   int          errors = 0;
   int          sent = 0;
   int          received = 0;
   bit          calm = 0;   // no idling on either side when set

   function automatic logic [31:0] feistel(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   function automatic logic [63:0] keystream(input logic [63:0] ctr);
      logic [31:0] v0, v1, s;
      v0 = ctr[31:0];
      v1 = ctr[63:32];
      s = 0;
      for (int r = 0; r < ROUNDS; r++) begin
         s += xtea_pkg::ROUND_DELTA;
         v0 += feistel(v1) ^ (s + key_copy[s[1:0]]);
         v1 += feistel(v0) ^ (s + key_copy[s[12:11]]);
      end
      return {v1, v0};
   endfunction

   task automatic predict_item(input logic [63:0] d, input logic [3:0] n, input bit som);
      logic [63:0] mask;
      if (som) ctr_copy = nonce_copy;
      if (n >= 8) mask = '1;
      else if (n == 0) mask = '0;
      else mask = (64'd1 << (8 * n)) - 1;
      want_word.push_back(d ^ (keystream(ctr_copy) & mask));
      want_count.push_back(n);
      ctr_copy += 1;
   endtask

   // valid stays up after acceptance until the next item or an idle cycle
   task automatic send_item(input logic [63:0] d, input logic [3:0] n, input bit som);
      while (!calm && $urandom_range(99) < 13) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_data_word <= d;
      req_byte_count <= n;
      req_start_of_message <= som;
      do @(posedge clock); while (!req_ready);
      predict_item(d, n, som);
      sent++;
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      if (idx == xtea_pkg::REG_START) nonce_copy = val;
      else key_copy[idx[1:0]] = val[31:0];
   endtask

   task automatic drain;
      req_valid <= 0;
      while (want_word.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   task automatic set_keys(input logic [31:0] a, b, c, d, input logic [63:0] nonce);
      drain();
      write_reg(xtea_pkg::REG_KEY0, a);
      write_reg(xtea_pkg::REG_KEY1, b);
      write_reg(xtea_pkg::REG_KEY2, c);
      write_reg(xtea_pkg::REG_KEY3, d);
      write_reg(xtea_pkg::REG_START, nonce);
      csr_write <= 0;
   endtask

   // result side
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            received++;
            if (want_word.size() == 0) begin
               $display("%0t: unexpected result word %h count %0d", $time,
                        rsp_result_word, rsp_result_count);
               errors++;
            end else begin
               if (rsp_result_word !== want_word[0]) begin
                  $display("%0t: result_word expected %h actual %h", $time,
                           want_word[0], rsp_result_word);
                  errors++;
               end
               if (rsp_result_count !== want_count[0]) begin
                  $display("%0t: result_count expected %0d actual %0d", $time,
                           want_count[0], rsp_result_count);
                  errors++;
               end
               void'(want_word.pop_front());
               void'(want_count.pop_front());
            end
         end
         rsp_ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   task automatic test_before_start;
      // counter is zero after reset, keys all zero
      send_item(64'h0123_4567_89ab_cdef, 4'd8, 1'b0);
      send_item('1, 4'd3, 1'b0);
   endtask

   task automatic test_counts;
      send_item('0, 4'd8, 1'b1);
      for (int n = 0; n <= 15; n++) send_item('1, n[3:0], 1'b0);
      send_item(64'h8000_0000_0000_0001, 4'd8, 1'b0);
   endtask

   task automatic test_counter_edges;
      set_keys('1, '1, '1, '1, '1);
      send_item('0, 4'd8, 1'b1);
      send_item('0, 4'd8, 1'b0);   // wraps to zero
      set_keys(32'h01234567, 32'h89abcdef, 32'hfedcba98, 32'h76543210, '0);
      send_item(64'haaaa_5555_aaaa_5555, 4'd8, 1'b1);
      send_item(64'h5555_aaaa_5555_aaaa, 4'd1, 1'b0);
   endtask

   task automatic test_random_messages(input int items);
      int left, len;
      left = items;
      while (left > 0) begin
         if ($urandom_range(3) == 0)
            set_keys($urandom, $urandom, $urandom, $urandom,
                     ($urandom_range(4) == 0) ? 64'hffff_ffff_ffff_fff0
                                              : {$urandom, $urandom});
         len = $urandom_range(1, 24);
         for (int i = 0; i < len && left > 0; i++, left--) begin
            logic [3:0] n;
            n = (i == len - 1) ? 4'($urandom_range(1, 8)) : 4'd8;
            if ($urandom_range(19) == 0) n = 4'($urandom);   // noise
            send_item({$urandom, $urandom}, n, (i == 0) || ($urandom_range(49) == 0));
         end
      end
   endtask

   initial begin
      key_copy = '{default: 0};
      nonce_copy = 64'd1;
      ctr_copy = '0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_before_start();
      test_counts();
      test_counter_edges();
      test_random_messages(400);
      calm = 1;
      test_random_messages(200);
      calm = 0;
      test_random_messages(250);
      drain();
      $display("Sent %0d items, checked %0d results over several keys and nonces,",
               sent, received);
      $display("including counter wrap, all byte counts and receiver stalls.");
      if (errors == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout");
      $display("DONE: errors detected");
      $finish;
   end
endmodule
`default_nettype wire
